// File: rtl/afskdm_pkg.sv
// ----------------------------------------------------------------------------
// afskdm_pkg: shared types and constants of the AFSK demodulator
// Sizes of the delay line, the datapath words and the bit clock.
// ----------------------------------------------------------------------------
package afskdm_pkg;

  localparam int unsigned DelayTaps        = 4;
  localparam int unsigned SamplesPerBitLog2 = 3;

  localparam int unsigned SampleW  = 8;   // converter code
  localparam int unsigned CenterW  = 9;   // centered sample, signed
  localparam int unsigned ProductW = 2 * CenterW;
  localparam int unsigned MixW     = 15;  // mixer output, signed
  localparam int unsigned FiltW    = 18;  // low-pass output, signed
  localparam int unsigned PhaseW   = 32;

  localparam logic [SampleW-1:0] CenterReset = SampleW'(127);

  // phase advance per sample: one full turn every 2^SamplesPerBitLog2 samples
  localparam logic [PhaseW-1:0] PhaseStep =
    PhaseW'(64'd1 << (PhaseW - SamplesPerBitLog2));

  typedef logic signed [CenterW-1:0] centered_t;

  // one recovered bit from the demod core
  typedef struct packed {
    logic valid;
    logic data;
  } afskdm_bit_t;

endpackage

// File: rtl/afskdm_core.sv
// ----------------------------------------------------------------------------
// afskdm_core: delay-multiply mixer, low-pass, tone slicer and bit clock
// Updates all demodulator state for one centered sample per enabled cycle.
// ----------------------------------------------------------------------------
module afskdm_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  afskdm_pkg::centered_t  centered_i,
  output afskdm_pkg::afskdm_bit_t bit_o
);
  import afskdm_pkg::*;

  centered_t                  taps_q [DelayTaps];
  logic signed [MixW-1:0]     mixed_last_q;
  logic signed [FiltW-1:0]    filter_q, filter_d;
  logic        [PhaseW-1:0]   phase_q, phase_half, phase_d;
  logic                       last_tone_q, nrzi_q;

  logic signed [ProductW-1:0] product;
  logic signed [MixW-1:0]     mixed_d;
  logic                       tone;
  logic                       wrap;

  // the previous mixer output of the filter is mixed_last_q itself
  always_comb begin
    product  = taps_q[DelayTaps-1] * centered_i;
    mixed_d  = MixW'(product >>> 2);
    filter_d = FiltW'(mixed_last_q) + FiltW'(mixed_d) + (filter_q >>> 1);
    tone     = !filter_d[FiltW-1] && (filter_d != '0);

    // halve the phase on each tone transition to pull toward the bit center
    if (tone != last_tone_q) begin
      phase_half = {phase_q[PhaseW-1], phase_q[PhaseW-1:1]};
    end else begin
      phase_half = phase_q;
    end
    phase_d = phase_half + PhaseStep;
    wrap    = phase_d[PhaseW-1] && !phase_half[PhaseW-1] && (phase_half != '0);

    bit_o.valid = en_i && wrap;
    bit_o.data  = (nrzi_q == tone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DelayTaps; i++) begin
        taps_q[i] <= '0;
      end
      mixed_last_q   <= '0;
      filter_q       <= '0;
      phase_q        <= '0;
      last_tone_q    <= 1'b0;
      nrzi_q         <= 1'b1;
    end else if (en_i) begin
      taps_q[0] <= centered_i;
      for (int i = 1; i < DelayTaps; i++) begin
        taps_q[i] <= taps_q[i-1];
      end
      mixed_last_q   <= mixed_d;
      filter_q       <= filter_d;
      phase_q        <= phase_d;
      last_tone_q    <= tone;
      if (wrap) begin
        nrzi_q <= tone;
      end
    end
  end

endmodule

// File: rtl/afsk_delay_multiply_demodulator.sv
// ----------------------------------------------------------------------------
// afsk_delay_multiply_demodulator: Bell 202 style AFSK receive demodulator
// Delay-and-multiply discriminator, IIR low-pass, bit clock and NRZI decode.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------
//  config   | in        | cfg_valid_i/cfg_ready_o | adc_center_i  [7:0]
//  samples  | in        | in_valid_i/in_ready_o   | adc_sample_i  [7:0]
//  bits     | out       | out_valid_o/out_ready_i | data_bit_o
//
//  One sample transaction per clock, sustained while the output is ready.
//  A sample is centered and captured in the input register; when the core
//  advances, it updates all filter and phase state from that sample and a
//  recovered bit, if any, loads the output register. The rate is set by
//  the combinational state update in the core: 9x9 multiply, filter add
//  and phase add. Reset clears the delay line, filter and phase and sets
//  adc_center to 127. While a bit waits in a stalled output register the
//  input register holds, so one more sample is taken and then in_ready_o
//  drops until the bit is accepted.
//
module afsk_delay_multiply_demodulator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [afskdm_pkg::SampleW-1:0] adc_center_i,
  // samples
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [afskdm_pkg::SampleW-1:0] adc_sample_i,
  // recovered bits
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       data_bit_o
);
  import afskdm_pkg::*;

  logic [SampleW-1:0] center_q;
  logic               s_valid_q;
  centered_t          s_sample_q;
  logic               out_valid_q, out_bit_q;
  logic               advance;
  logic               in_take;
  afskdm_bit_t        core_bit;

  // config is always accepted; writes must only arrive while idle, the block itself does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CenterReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      center_q <= adc_center_i;
    end
  end

  // Input register advances only when the output register has room.
  assign advance    = s_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  // payload register, no reset needed; centered at capture time
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s_sample_q <= $signed({1'b0, adc_sample_i}) - $signed({1'b0, center_q});
    end
  end

  afskdm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .centered_i (s_sample_q),
    .bit_o      (core_bit)
  );

  // result register: loads a new bit, otherwise drains on handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_bit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_bit.valid) begin
      out_bit_q <= core_bit.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_bit_o  = out_bit_q;

`ifndef NO_ASSERTIONS
  // core only reports a bit on a cycle where it consumes a sample
  a_bit_needs_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_bit.valid |-> advance)
    else $error("core bit without advance");

  // a new bit is never dropped into an occupied, stalled output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_bit.valid |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // a bit from the core shows up at the output next cycle
  a_bit_presented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_bit.valid |=> out_valid_o)
    else $error("core bit not presented");

  // a held sample stays held until the core takes it
  a_sample_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_q && !advance) |=> s_valid_q)
    else $error("pending sample lost");

  // an empty input register is always ready for a sample
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_valid_q |-> in_ready_o)
    else $error("input stalled while empty");
`endif

endmodule
